/* src/cfnp_pkg.sv */
// ----------------------------------------------------------------------------
// cfnp_pkg
// shared widths, action codes and defaults for the purge fifo
// ----------------------------------------------------------------------------
`default_nettype none

package cfnp_pkg;

    localparam int DATA_W        = 32;
    localparam int ACT_W         = 2;
    localparam int DEFAULT_DEPTH = 8;

    // action codes carried by each input beat
    localparam logic [ACT_W-1:0] ACT_ENQ   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DEQ   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_PURGE = 2'd2;

endpackage

`default_nettype wire

/* src/cfnp_ram.sv */
// ----------------------------------------------------------------------------
// cfnp_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module cfnp_ram #(
    parameter int WIDTH = cfnp_pkg::DATA_W,
    parameter int DEPTH = cfnp_pkg::DEFAULT_DEPTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* src/circular_fifo_with_negative_purge_core.sv */
// ----------------------------------------------------------------------------
// circular_fifo_with_negative_purge_core
// ring buffer fifo of signed words with enqueue, dequeue and negative purge
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                 payload
//  -------  ---------  ------------------------  -------------------------------
//  in       sink       i_in_valid / o_in_stall   i_action, i_data_in
//  out      source     o_out_valid / i_out_stall o_data_out, o_data_valid,
//                                                o_rejected, o_is_empty, o_is_full
//
//  one beat at a time: enqueue and idle codes pass the exec and result
//  states, dequeue adds a state for the registered ram read when a word
//  is read, none on an empty ring, purge walks every occupied entry in the
//  purge state over the entry ram with one read and one write port per cycle
//  reset is synchronous, active low; clears pointers, count and control only
//  a result waiting on a stalled output blocks the next input beat: the input
//  stays stalled until the result moves into the output register
//
`default_nettype none

module circular_fifo_with_negative_purge_core #(
    parameter int DEPTH = cfnp_pkg::DEFAULT_DEPTH
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // input channel
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [cfnp_pkg::ACT_W-1:0]         i_action,
    input  wire logic signed [cfnp_pkg::DATA_W-1:0] i_data_in,
    // output channel
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic signed [cfnp_pkg::DATA_W-1:0]      o_data_out,
    output logic                                    o_data_valid,
    output logic                                    o_rejected,
    output logic                                    o_is_empty,
    output logic                                    o_is_full
);

    localparam int DW = cfnp_pkg::DATA_W;
    localparam int AW = $clog2(DEPTH);      // ram index width
    localparam int CW = $clog2(DEPTH + 1);  // occupancy width, holds DEPTH itself

    localparam logic [AW:0]   DEPTH_X = (AW+1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_DEQ_RD = 3'd2;
    localparam logic [2:0] S_PURGE  = 3'd3;
    localparam logic [2:0] S_RES    = 3'd4;

    // modular add of two ring indices, operands always below DEPTH
    function automatic logic [AW-1:0] f_wrap(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= DEPTH_X) begin
            s = s - DEPTH_X;
        end
        return s[AW-1:0];
    endfunction

    // control state
    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_head,  n_head;
    logic [CW-1:0] r_occ,   n_occ;
    logic          r_out_valid, n_out_valid;

    // captured beat and walk counters
    logic [cfnp_pkg::ACT_W-1:0] r_act,  n_act;
    logic [DW-1:0]              r_data, n_data;
    logic [AW-1:0]              r_k,    n_k;     // entry being examined in purge
    logic [CW-1:0]              r_kept, n_kept;  // survivors packed so far

    // pending result
    logic [DW-1:0] r_res_data, n_res_data;
    logic          r_res_dv,   n_res_dv;
    logic          r_res_rej,  n_res_rej;

    // output register
    logic [DW-1:0] r_out_data,  n_out_data;
    logic          r_out_dv,    n_out_dv;
    logic          r_out_rej,   n_out_rej;
    logic          r_out_empty, n_out_empty;
    logic          r_out_full,  n_out_full;

    // ram ports
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [DW-1:0] ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [DW-1:0] ram_rd_data;

    logic in_acc;
    logic out_free;
    logic word_neg;
    logic walk_last;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    // output slot empty, or its beat leaves at this edge
    assign out_free   = !r_out_valid || !i_out_stall;

    assign word_neg  = ram_rd_data[DW-1];
    assign walk_last = ((CW'(r_k) + ONE_C) == r_occ);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_occ       = r_occ;
        n_act       = r_act;
        n_data      = r_data;
        n_k         = r_k;
        n_kept      = r_kept;
        n_res_data  = r_res_data;
        n_res_dv    = r_res_dv;
        n_res_rej   = r_res_rej;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_dv    = r_out_dv;
        n_out_rej   = r_out_rej;
        n_out_empty = r_out_empty;
        n_out_full  = r_out_full;

        ram_wr_en   = 1'b0;
        ram_wr_addr = f_wrap(r_head, r_kept[AW-1:0]);
        ram_wr_data = ram_rd_data;
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_head;

        // downstream took the beat
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_act   = i_action;
                    n_data  = i_data_in;
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_res_data = '0;
                n_res_dv   = 1'b0;
                n_res_rej  = 1'b0;
                n_state    = S_RES;
                case (r_act)
                    cfnp_pkg::ACT_ENQ: begin
                        if (r_occ == DEPTH_C) begin
                            n_res_rej = 1'b1;
                        end else begin
                            // tail slot sits occupancy entries past the head
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = f_wrap(r_head, r_occ[AW-1:0]);
                            ram_wr_data = r_data;
                            n_occ       = r_occ + ONE_C;
                        end
                    end
                    cfnp_pkg::ACT_DEQ: begin
                        if (r_occ != '0) begin
                            ram_rd_en = 1'b1;
                            n_state   = S_DEQ_RD;
                        end
                    end
                    cfnp_pkg::ACT_PURGE: begin
                        if (r_occ != '0) begin
                            // start the walk at the head, survivors repack from there
                            ram_rd_en = 1'b1;
                            n_k       = '0;
                            n_kept    = '0;
                            n_state   = S_PURGE;
                        end
                    end
                    default: begin
                        // unused code, status only
                    end
                endcase
            end

            S_DEQ_RD: begin
                n_res_data = ram_rd_data;
                n_res_dv   = 1'b1;
                n_occ      = r_occ - ONE_C;
                if (r_occ == ONE_C) begin
                    n_head = '0;
                end else begin
                    n_head = f_wrap(r_head, AW'(1));
                end
                n_state = S_RES;
            end

            S_PURGE: begin
                // read data holds entry r_k; keep it if the sign bit is clear
                if (!word_neg) begin
                    ram_wr_en = 1'b1;
                    n_kept    = r_kept + ONE_C;
                end
                if (walk_last) begin
                    n_occ = n_kept;
                    if (n_kept == '0) begin
                        n_head = '0;
                    end
                    n_state = S_RES;
                end else begin
                    // next read runs ahead of every pending write slot
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = f_wrap(r_head, r_k + AW'(1));
                    n_k         = r_k + AW'(1);
                end
            end

            S_RES: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res_data;
                    n_out_dv    = r_res_dv;
                    n_out_rej   = r_res_rej;
                    n_out_empty = (r_occ == '0);
                    n_out_full  = (r_occ == DEPTH_C);
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_act       <= n_act;
        r_data      <= n_data;
        r_k         <= n_k;
        r_kept      <= n_kept;
        r_res_data  <= n_res_data;
        r_res_dv    <= n_res_dv;
        r_res_rej   <= n_res_rej;
        r_out_data  <= n_out_data;
        r_out_dv    <= n_out_dv;
        r_out_rej   <= n_out_rej;
        r_out_empty <= n_out_empty;
        r_out_full  <= n_out_full;
    end

    cfnp_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_entries (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign o_out_valid  = r_out_valid;
    assign o_data_out   = r_out_data;
    assign o_data_valid = r_out_dv;
    assign o_rejected   = r_out_rej;
    assign o_is_empty   = r_out_empty;
    assign o_is_full    = r_out_full;

`ifndef SYNTHESIS
    // occupancy never passes the ring size
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= DEPTH_C)
        else $error("occupancy above depth");

    // an empty ring always has its head back at slot zero
    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_occ == '0) |-> (r_head == '0))
        else $error("empty ring with head off zero");

    // packing never overtakes the walk
    a_kept_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PURGE) |-> (r_kept <= CW'(r_k)))
        else $error("purge write ahead of read");

    // a dequeued word and a full-queue reject never share a beat
    a_dv_rej: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_data_valid && o_rejected))
        else $error("valid data and reject together");
`endif

endmodule

`default_nettype wire

/* dv/circular_fifo_with_negative_purge_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_fifo_with_negative_purge_core_tb
// self-checking bench for the purge fifo: a short directed table covering
// empty, full, purge and spare-code corners, then biased random beats
// with random idle bursts on both channels, every result checked in order
// against a cycle-free model of the queue
// ----------------------------------------------------------------------------

module circular_fifo_with_negative_purge_core_tb;

    localparam int DEPTH       = cfnp_pkg::DEFAULT_DEPTH;
    localparam int RAND_BEATS  = 625;
    localparam int QUIET_BEATS = 80;      // tail of the run with no idling
    localparam int CYCLE_LIMIT = 300000;
    localparam int TAIL_CYCLES = DEPTH + 16;

    // action code the block must treat as a no-op
    localparam logic [cfnp_pkg::ACT_W-1:0] ACT_SPARE = 2'd3;

    typedef struct packed {
        logic signed [cfnp_pkg::DATA_W-1:0] data_out;
        logic                               data_valid;
        logic                               rejected;
        logic                               is_empty;
        logic                               is_full;
    } t_fifo_result;

    typedef struct packed {
        logic [cfnp_pkg::ACT_W-1:0]         act;
        logic signed [cfnp_pkg::DATA_W-1:0] word;
        logic                               typed;     // expectation written by hand
        t_fifo_result                       want;
    } t_table_row;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               i_in_valid;
    logic                               o_in_stall;
    logic [cfnp_pkg::ACT_W-1:0]         i_action;
    logic signed [cfnp_pkg::DATA_W-1:0] i_data_in;
    logic                               o_out_valid;
    logic                               i_out_stall;
    logic signed [cfnp_pkg::DATA_W-1:0] o_data_out;
    logic                               o_data_valid;
    logic                               o_rejected;
    logic                               o_is_empty;
    logic                               o_is_full;

    circular_fifo_with_negative_purge_core #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_data_in   (i_data_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_data_out  (o_data_out),
        .o_data_valid(o_data_valid),
        .o_rejected  (o_rejected),
        .o_is_empty  (o_is_empty),
        .o_is_full   (o_is_full)
    );

    // queue model state
    logic signed [cfnp_pkg::DATA_W-1:0] ring_mem [DEPTH];
    int                                 ring_head;
    int                                 ring_count;

    t_fifo_result result_q [$];
    t_table_row   corner_rows [$];

    int  error_count;
    int  cycle_count;
    int  beats_sent;
    int  results_seen;
    int  words_popped;
    int  full_rejects;
    int  purges_done;
    int  spare_beats;
    int  stall_left;
    bit  quiet;

    // ------------------------------------------------------------------------
    // clock, cycle counter and watchdog
    // ------------------------------------------------------------------------
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, result_q.size());
            $display("circular_fifo_with_negative_purge_core_tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // queue model: one call per accepted beat, returns the one result it owes
    // ------------------------------------------------------------------------
    function automatic t_fifo_result fifo_predict(
            input logic [cfnp_pkg::ACT_W-1:0] act,
            input logic signed [cfnp_pkg::DATA_W-1:0] word);
        t_fifo_result r;
        int           kept;
        int           src;
        int           k;
        r = '0;
        case (act)
            cfnp_pkg::ACT_ENQ: begin
                if (ring_count >= DEPTH) begin
                    r.rejected = 1'b1;
                end else begin
                    ring_mem[(ring_head + ring_count) % DEPTH] = word;
                    ring_count++;
                end
            end
            cfnp_pkg::ACT_DEQ: begin
                if (ring_count != 0) begin
                    r.data_out   = ring_mem[ring_head];
                    r.data_valid = 1'b1;
                    ring_count--;
                    // last word out sends the head home
                    ring_head = (ring_count == 0) ? 0 : (ring_head + 1) % DEPTH;
                end
            end
            cfnp_pkg::ACT_PURGE: begin
                if (ring_count != 0) begin
                    // compact the survivors from the head on, order kept
                    kept = 0;
                    for (k = 0; k < ring_count; k++) begin
                        src = (ring_head + k) % DEPTH;
                        if (!ring_mem[src][cfnp_pkg::DATA_W-1]) begin
                            ring_mem[(ring_head + kept) % DEPTH] = ring_mem[src];
                            kept++;
                        end
                    end
                    ring_count = kept;
                    if (kept == 0)
                        ring_head = 0;
                end
            end
            default: begin
                // spare code: status only
            end
        endcase
        r.is_empty = (ring_count == 0);
        r.is_full  = (ring_count == DEPTH);
        return r;
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [cfnp_pkg::DATA_W-1:0] got,
                                   input logic [cfnp_pkg::DATA_W-1:0] want);
        $display("mismatch at cycle %0d, result %0d: %s got %h want %h",
                 cycle_count, results_seen, what, got, want);
        error_count++;
    endtask

    // ------------------------------------------------------------------------
    // input driver: payload changes on the falling edge, accept on the rising
    // ------------------------------------------------------------------------
    task automatic send_beat(input logic [cfnp_pkg::ACT_W-1:0] act,
                             input logic signed [cfnp_pkg::DATA_W-1:0] word,
                             input logic typed, input t_fifo_result want);
        t_fifo_result predicted;
        int           gap;
        // random idle burst ahead of this beat
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 17);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_data_in  <= word;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        // beat accepted on this edge
        predicted = fifo_predict(act, word);
        result_q.push_back(typed ? want : predicted);
        beats_sent++;
        if (act == cfnp_pkg::ACT_DEQ && predicted.data_valid)
            words_popped++;
        if (predicted.rejected)
            full_rejects++;
        if (act == cfnp_pkg::ACT_PURGE)
            purges_done++;
        if (act == ACT_SPARE)
            spare_beats++;
        @(negedge i_clk);
    endtask

    task automatic add_row(input logic [cfnp_pkg::ACT_W-1:0] act,
                           input logic [cfnp_pkg::DATA_W-1:0] word,
                           input logic typed, input t_fifo_result want);
        t_table_row row;
        row.act   = act;
        row.word  = word;
        row.typed = typed;
        row.want  = want;
        corner_rows.push_back(row);
    endtask

    // ------------------------------------------------------------------------
    // output side: random stall bursts, switched off for the quiet tail
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n || quiet) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 16);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // result checker: each accepted beat against the oldest expectation
    always @(posedge i_clk) begin
        t_fifo_result want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            results_seen++;
            if (result_q.size() == 0) begin
                report_mismatch("result beat with nothing expected", o_data_out, '0);
            end else begin
                want = result_q.pop_front();
                if (o_data_out !== want.data_out)
                    report_mismatch("data_out", o_data_out, want.data_out);
                if (o_data_valid !== want.data_valid)
                    report_mismatch("data_valid", 32'(o_data_valid), 32'(want.data_valid));
                if (o_rejected !== want.rejected)
                    report_mismatch("rejected", 32'(o_rejected), 32'(want.rejected));
                if (o_is_empty !== want.is_empty)
                    report_mismatch("is_empty", 32'(o_is_empty), 32'(want.is_empty));
                if (o_is_full !== want.is_full)
                    report_mismatch("is_full", 32'(o_is_full), 32'(want.is_full));
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_fifo_result                       none;
        t_fifo_result                       empty_flags;
        t_table_row                         row;
        logic [cfnp_pkg::ACT_W-1:0]         act;
        logic signed [cfnp_pkg::DATA_W-1:0] word;
        int                                 enq_weight;
        int                                 pick;
        int                                 n;

        error_count  = 0;
        cycle_count  = 0;
        beats_sent   = 0;
        results_seen = 0;
        words_popped = 0;
        full_rejects = 0;
        purges_done  = 0;
        spare_beats  = 0;
        stall_left   = 0;
        quiet        = 1'b0;
        ring_head    = 0;
        ring_count   = 0;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_action    <= cfnp_pkg::ACT_ENQ;
        i_data_in   <= '0;
        i_out_stall <= 1'b0;

        none        = '0;
        empty_flags = '0;
        empty_flags.is_empty = 1'b1;

        // corner table; hand-written expectations only where obvious
        add_row(cfnp_pkg::ACT_DEQ,   32'h0, 1'b1, empty_flags);     // pop on empty
        add_row(cfnp_pkg::ACT_PURGE, 32'h0, 1'b1, empty_flags);     // purge of nothing
        add_row(ACT_SPARE, 32'h0, 1'b1, empty_flags);               // spare code
        add_row(cfnp_pkg::ACT_ENQ, 32'h7FFF_FFFF, 1'b0, none);
        add_row(cfnp_pkg::ACT_ENQ, 32'h8000_0000, 1'b0, none);
        add_row(cfnp_pkg::ACT_ENQ, 32'h0000_0000, 1'b0, none);
        add_row(cfnp_pkg::ACT_ENQ, 32'hFFFF_FFFF, 1'b0, none);
        add_row(cfnp_pkg::ACT_ENQ, 32'h0000_0001, 1'b0, none);
        add_row(cfnp_pkg::ACT_ENQ, 32'hC000_0000, 1'b0, none);
        add_row(cfnp_pkg::ACT_ENQ, 32'h1234_5678, 1'b0, none);
        add_row(cfnp_pkg::ACT_ENQ, 32'hFFFF_FFFE, 1'b1, '{data_out: '0, data_valid: 1'b0,
                rejected: 1'b0, is_empty: 1'b0, is_full: 1'b1});   // now full
        add_row(cfnp_pkg::ACT_ENQ, 32'h5555_AAAA, 1'b1, '{data_out: '0, data_valid: 1'b0,
                rejected: 1'b1, is_empty: 1'b0, is_full: 1'b1});   // push on full
        add_row(cfnp_pkg::ACT_DEQ, 32'h0, 1'b1, '{data_out: 32'h7FFF_FFFF, data_valid: 1'b1,
                rejected: 1'b0, is_empty: 1'b0, is_full: 1'b0});   // oldest out
        add_row(cfnp_pkg::ACT_PURGE, 32'h0, 1'b0, none);            // mixed signs
        add_row(cfnp_pkg::ACT_ENQ, 32'hFFFF_FFFB, 1'b0, none);
        add_row(cfnp_pkg::ACT_ENQ, 32'h0000_0009, 1'b0, none);
        add_row(cfnp_pkg::ACT_DEQ, 32'h0, 1'b0, none);
        add_row(cfnp_pkg::ACT_DEQ, 32'h0, 1'b0, none);
        add_row(cfnp_pkg::ACT_DEQ, 32'h0, 1'b0, none);
        add_row(cfnp_pkg::ACT_DEQ, 32'h0, 1'b0, none);
        add_row(cfnp_pkg::ACT_DEQ, 32'h0, 1'b0, none);              // last word out
        add_row(cfnp_pkg::ACT_ENQ, 32'h8000_0000, 1'b0, none);
        add_row(cfnp_pkg::ACT_ENQ, 32'hFFFF_FFFF, 1'b0, none);
        add_row(cfnp_pkg::ACT_PURGE, 32'h0, 1'b1, empty_flags);     // all negative

        // reset, then release on a falling edge
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (corner_rows[i]) begin
            row = corner_rows[i];
            send_beat(row.act, row.word, row.typed, row.want);
        end

        // random beats, action mix drifts between filling and draining
        enq_weight = 50;
        for (n = 0; n < RAND_BEATS; n++) begin
            if (n % 40 == 0)
                enq_weight = $urandom_range(20, 80);
            if (n == RAND_BEATS - QUIET_BEATS)
                quiet = 1'b1;
            // hold the sender until the block has handed back everything
            if (n == RAND_BEATS / 2) begin
                i_in_valid <= 1'b0;
                while (result_q.size() != 0)
                    @(negedge i_clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 3)
                act = ACT_SPARE;
            else if (pick < 13)
                act = cfnp_pkg::ACT_PURGE;
            else if (pick < 13 + (enq_weight * 87) / 100)
                act = cfnp_pkg::ACT_ENQ;
            else
                act = cfnp_pkg::ACT_DEQ;
            case ($urandom_range(0, 9))
                0:       word = 32'h8000_0000;
                1:       word = 32'h7FFF_FFFF;
                2:       word = -$signed(32'(16'($urandom)));
                3:       word = $signed(32'(16'($urandom)));
                default: word = $urandom;
            endcase
            send_beat(act, word, 1'b0, none);
        end

        // drain, then let the pipe settle to catch stray beats
        i_in_valid <= 1'b0;
        while (result_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (result_q.size() != 0)
            report_mismatch("expectations left over", result_q.size(), 0);

        $display("covered %0d beats, %0d results: %0d words popped, %0d full rejects",
                 beats_sent, results_seen, words_popped, full_rejects);
        $display("  %0d purges and %0d spare-code beats in %0d cycles",
                 purges_done, spare_beats, cycle_count);
        if (error_count == 0) begin
            $display("circular_fifo_with_negative_purge_core_tb: done, clean");
        end else begin
            $display("%0d mismatches", error_count);
            $display("circular_fifo_with_negative_purge_core_tb: done, errors");
        end
        $finish;
    end

endmodule

/* circular_fifo_with_negative_purge_core.f */
src/cfnp_pkg.sv
src/cfnp_ram.sv
src/circular_fifo_with_negative_purge_core.sv
dv/circular_fifo_with_negative_purge_core_tb.sv
